// ===== rtl/binary_to_decimal_ascii_macros.svh =====
// Assertion helpers shared by the converter's modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/b2da_pkg.sv =====
package b2da_pkg;

  // Beat carried by the input channel.
  typedef struct packed {
    logic [63:0] value;
    logic        signed_mode;
  } b2da_in_t;

  // Beat carried by the output channel.
  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       error;
  } b2da_out_t;

  // Widths of the working remainder and of the digit position.
  localparam int unsigned REM_W = 60;
  localparam int unsigned POS_W = 5;

  // Largest unsigned value that is still printed.
  localparam logic [63:0] DEC_LIMIT = 64'd1000000000000000000;

  // Starting digit positions (power of ten of the leading digit).
  localparam logic [POS_W-1:0] POS_U64 = 5'd18;
  localparam logic [POS_W-1:0] POS_S32 = 5'd9;

  // Character codes.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Table of multiples k * 10^p for p = 0..18 and k = 1..9.
  typedef logic [9:1][63:0] mult_row_t;
  typedef mult_row_t [18:0] mult_tab_t;

  function automatic mult_tab_t build_mult_tab();
    mult_tab_t   tab;
    logic [63:0] pw;
    tab = '0;
    pw  = 64'd1;
    for (int i = 0; i < 19; i++) begin
      for (int k = 1; k < 10; k++) begin
        tab[i][k] = pw * 64'(k);
      end
      pw = pw * 64'd10;
    end
    return tab;
  endfunction

  localparam mult_tab_t MULT_TAB = build_mult_tab();

endpackage

// ===== rtl/b2da_digit_unit.sv =====
// Shared digit extractor: finds the largest multiple of 10^pos that fits
// in the remainder, giving the decimal digit at that position and the
// remainder left once that multiple is taken away.
module b2da_digit_unit (
  input  logic [b2da_pkg::REM_W-1:0] rem_in,
  input  logic [b2da_pkg::POS_W-1:0] pos,
  output logic [3:0]                 digit,
  output logic [b2da_pkg::REM_W-1:0] rem_out
);

  logic [63:0] rem_wide;
  logic [63:0] sub;

  assign rem_wide = {{(64 - b2da_pkg::REM_W){1'b0}}, rem_in};

  // Nine parallel compares against the constant multiples; the highest hit wins.
  always_comb begin
    digit = 4'd0;
    sub   = 64'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem_wide >= b2da_pkg::MULT_TAB[pos][k]) begin
        digit = 4'(k);
        sub   = b2da_pkg::MULT_TAB[pos][k];
      end
    end
  end

  // One subtract of the selected multiple.
  assign rem_out = b2da_pkg::REM_W'(rem_wide - sub);

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter.
// Input channel (in_valid / in_stall / in_data): one beat carries a number and
// its mode. Unsigned mode prints 64-bit values up to 10^18; signed mode prints
// the low 32 bits as two's complement, with a leading '-' when negative.
// Output channel (out_valid / out_stall / out_data): one beat per character,
// most significant digit first, no leading zeros, last set on the final beat.
// An unsigned value above 10^18 gives a single beat with error and last set.
// Order: an accepted beat first loads the sequencer state, remainder and
// position; the sign beat, error beat or leading digit is then loaded into the
// output register, and each skipped leading zero position takes its own step.
// Throughput: one digit position is examined per cycle, while the receiver does
// not stall, by a shared compare and subtract unit; an unsigned item covers 19
// positions, a signed item 10 positions after any sign beat; the error case
// gives one beat. in_stall stays high until the last beat has been loaded.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits before every beat it needs to load; skipped leading zeros
// still advance one position per cycle.
// Reset (rst_n low, synchronous) empties the output register and returns the
// sequencer to idle; no state is kept between items.
`include "binary_to_decimal_ascii_macros.svh"

module binary_to_decimal_ascii (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  b2da_pkg::b2da_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output b2da_pkg::b2da_out_t  out_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERR,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  state_t                       state_r, state_nxt;
  logic [b2da_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [b2da_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic                         started_r, started_nxt;
  logic                         out_valid_r, out_valid_nxt;
  b2da_pkg::b2da_out_t          out_data_r, out_data_nxt;

  logic                         can_load;
  logic                         need_emit;
  logic [31:0]                  mag32;
  logic [3:0]                   unit_digit;
  logic [b2da_pkg::REM_W-1:0]   unit_rem;

  // Shared digit unit works on the current remainder and position.
  b2da_digit_unit u_digit (
    .rem_in  (rem_r),
    .pos     (pos_r),
    .digit   (unit_digit),
    .rem_out (unit_rem)
  );

  // Magnitude of the signed 32-bit value; the most negative value maps to 2^31.
  assign mag32 = in_data.value[31] ? 32'(-in_data.value[31:0]) : in_data.value[31:0];

  // The output register can take a beat when empty or being drained.
  assign can_load  = !out_valid_r || !out_stall;
  assign need_emit = started_r || (unit_digit != 4'd0) || (pos_r == '0);

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          started_nxt = 1'b0;
          if (!in_data.signed_mode) begin
            rem_nxt = in_data.value[b2da_pkg::REM_W-1:0];
            pos_nxt = b2da_pkg::POS_U64;
            if (in_data.value > b2da_pkg::DEC_LIMIT) begin
              state_nxt = ST_ERR;
            end else begin
              state_nxt = ST_DIGITS;
            end
          end else begin
            rem_nxt   = b2da_pkg::REM_W'(mag32);
            pos_nxt   = b2da_pkg::POS_S32;
            state_nxt = in_data.value[31] ? ST_SIGN : ST_DIGITS;
          end
        end
      end
      ST_ERR: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{character: b2da_pkg::CHAR_NUL, last: 1'b1, error: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end
      ST_SIGN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{character: b2da_pkg::CHAR_MINUS, last: 1'b0, error: 1'b0};
          state_nxt     = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (!need_emit || can_load) begin
          if (need_emit) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{character: b2da_pkg::CHAR_ZERO + {4'd0, unit_digit},
                              last: (pos_r == '0), error: 1'b0};
          end
          rem_nxt     = unit_rem;
          pos_nxt     = b2da_pkg::POS_W'(pos_r - 1'b1);
          started_nxt = started_r || need_emit;
          if (pos_r == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r      <= rem_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer and the beats it produces.
  `B2DA_ASSERT_NEXT(a_busy_after_accept,
    in_valid && !in_stall, in_stall,
    "accepted beat did not make the block busy")
  `B2DA_ASSERT_NOW(a_error_beat_shape,
    out_valid && out_data.error,
    out_data.last && (out_data.character == b2da_pkg::CHAR_NUL),
    "error beat must be last with a null character")
  `B2DA_ASSERT_NOW(a_char_range,
    out_valid && !out_data.error && (out_data.character != b2da_pkg::CHAR_MINUS),
    (out_data.character >= b2da_pkg::CHAR_ZERO) && (out_data.character <= 8'h39),
    "printed character is not a digit")
  `B2DA_ASSERT_NEXT(a_run_ends,
    (state_r == ST_DIGITS) && (pos_r == '0) && (!need_emit || can_load),
    state_r == ST_IDLE,
    "sequencer did not return to idle after the units digit")

endmodule
